// ===== rtl/lsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared types and constants of the block-push/pop LIFO stack.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbp_pkg;

    // sizing of the stack and of the request fields
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int COUNT_W     = 11;
    localparam int VALUE_W     = 32;
    // wide enough for fill + count without wrap, and for the 11-bit depth view
    localparam int WIDE_W      = ((FILL_W > COUNT_W) ? FILL_W : COUNT_W) + 1;

    // request kinds
    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREV_RD,
        ST_PREV_WAIT,
        ST_PUSH,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_DONE
    } t_state;

    // one stored word: value plus min and max of the entries at and below it
    typedef struct packed {
        logic signed [VALUE_W-1:0] val;
        logic signed [VALUE_W-1:0] min;
        logic signed [VALUE_W-1:0] max;
    } t_entry;

    // memory port command from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_cmd;

    // one result item
    typedef struct packed {
        logic [COUNT_W-1:0]        depth;
        logic signed [VALUE_W-1:0] top;
        logic                      empty;
        logic signed [VALUE_W-1:0] min;
        logic signed [VALUE_W-1:0] max;
        t_status                   status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lsbp_ram.sv =====
// ----------------------------------------------------------------------------
// lsbp_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbp_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lsbp_engine.sv =====
// ----------------------------------------------------------------------------
// lsbp_engine
// Request sequencer: fill level, push-run writes with running min/max,
// and the top-entry read that yields each result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbp_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire lsbp_pkg::t_req                i_req_type,
    input  wire logic signed [31:0]            i_req_start,
    input  wire logic [10:0]                   i_req_count,
    // result handoff to the output register
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output lsbp_pkg::t_result                  o_res,
    // memory
    output lsbp_pkg::t_ram_cmd                 o_ram_cmd,
    input  wire lsbp_pkg::t_entry              i_ram_rd_data
);

    import lsbp_pkg::*;

    t_state                    r_state,   n_state;
    logic [FILL_W-1:0]         r_fill,    n_fill;
    logic [COUNT_W-1:0]        r_left,    n_left;
    logic signed [VALUE_W-1:0] r_val,     n_val;
    logic signed [VALUE_W-1:0] r_run_min, n_run_min;
    logic signed [VALUE_W-1:0] r_run_max, n_run_max;
    logic                      r_run_ok,  n_run_ok;
    t_status                   r_status,  n_status;
    logic signed [VALUE_W-1:0] r_top,     n_top;
    logic signed [VALUE_W-1:0] r_min,     n_min;
    logic signed [VALUE_W-1:0] r_max,     n_max;

    logic                      accept;
    logic [WIDE_W-1:0]         push_sum;
    logic [WIDE_W-1:0]         fill_wide;
    logic [ADDR_W-1:0]         top_addr;
    logic signed [VALUE_W-1:0] push_min;
    logic signed [VALUE_W-1:0] push_max;

    assign accept    = i_req_valid && o_req_ready;
    assign fill_wide = WIDE_W'(r_fill);
    assign push_sum  = WIDE_W'(i_req_count) + fill_wide;
    assign top_addr  = ADDR_W'(r_fill - FILL_W'(1));

    // prefix min/max of the entry being written
    always_comb begin
        if (r_run_ok) begin
            push_min = (r_val < r_run_min) ? r_val : r_run_min;
            push_max = (r_val > r_run_max) ? r_val : r_run_max;
        end else begin
            push_min = r_val;
            push_max = r_val;
        end
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left    <= n_left;
        r_val     <= n_val;
        r_run_min <= n_run_min;
        r_run_max <= n_run_max;
        r_run_ok  <= n_run_ok;
        r_status  <= n_status;
        r_top     <= n_top;
        r_min     <= n_min;
        r_max     <= n_max;
    end

    // next state, memory commands and handshakes
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_left    = r_left;
        n_val     = r_val;
        n_run_min = r_run_min;
        n_run_max = r_run_max;
        n_run_ok  = r_run_ok;
        n_status  = r_status;
        n_top     = r_top;
        n_min     = r_min;
        n_max     = r_max;

        o_req_ready       = 1'b0;
        o_res_valid       = 1'b0;
        o_ram_cmd.wr_en   = 1'b0;
        o_ram_cmd.wr_addr = r_fill[ADDR_W-1:0];
        o_ram_cmd.wr_data = '{val: r_val, min: push_min, max: push_max};
        o_ram_cmd.rd_en   = 1'b0;
        o_ram_cmd.rd_addr = top_addr;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (accept) begin
                    n_status = STAT_OK;
                    n_state  = ST_TOP_RD;
                    case (i_req_type)
                        REQ_PUSH: begin
                            if (push_sum > WIDE_W'(STACK_DEPTH)) begin
                                n_status = STAT_OVERFLOW;
                            end else if (i_req_count != '0) begin
                                n_left   = i_req_count;
                                n_val    = i_req_start;
                                n_run_ok = 1'b0;
                                n_state  = (r_fill != '0) ? ST_PREV_RD : ST_PUSH;
                            end
                        end
                        REQ_POP: begin
                            if (WIDE_W'(i_req_count) > fill_wide) begin
                                n_fill   = '0;
                                n_status = STAT_UNDERFLOW;
                            end else begin
                                n_fill = r_fill - FILL_W'(i_req_count);
                            end
                        end
                        REQ_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                            n_fill = r_fill;
                        end
                    endcase
                end
            end
            // fetch the running extremes held with the current top
            ST_PREV_RD: begin
                o_ram_cmd.rd_en = 1'b1;
                n_state         = ST_PREV_WAIT;
            end
            ST_PREV_WAIT: begin
                n_run_min = i_ram_rd_data.min;
                n_run_max = i_ram_rd_data.max;
                n_run_ok  = 1'b1;
                n_state   = ST_PUSH;
            end
            // one entry of the run per cycle
            ST_PUSH: begin
                o_ram_cmd.wr_en = 1'b1;
                n_run_min       = push_min;
                n_run_max       = push_max;
                n_run_ok        = 1'b1;
                n_val           = r_val + VALUE_W'(1);
                n_fill          = r_fill + FILL_W'(1);
                n_left          = r_left - COUNT_W'(1);
                if (r_left == COUNT_W'(1)) begin
                    n_state = ST_TOP_RD;
                end
            end
            // read the top entry, or report zeros when empty
            ST_TOP_RD: begin
                if (r_fill != '0) begin
                    o_ram_cmd.rd_en = 1'b1;
                    n_state         = ST_TOP_WAIT;
                end else begin
                    n_top   = '0;
                    n_min   = '0;
                    n_max   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_TOP_WAIT: begin
                n_top   = i_ram_rd_data.val;
                n_min   = i_ram_rd_data.min;
                n_max   = i_ram_rd_data.max;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result fields
    assign o_res.depth  = fill_wide[COUNT_W-1:0];
    assign o_res.top    = r_top;
    assign o_res.empty  = (r_fill == '0);
    assign o_res.min    = r_min;
    assign o_res.max    = r_max;
    assign o_res.status = r_status;

endmodule

`default_nettype wire

// ===== rtl/lifo_stack_block_push_pop.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_block_push_pop
// Bounded LIFO stack of signed 32-bit words with push-run, pop-count, clear
// and query requests; each request returns fill, top, empty, min and max.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_valid/o_ready with i_req_type, i_start_value and
//   i_count; each transfer yields exactly one result on o_valid/i_ready.
//   Every stored word carries the min and max of itself and all entries
//   below it, so a result needs only one memory read of the top entry.
//   Path from request transfer to o_valid: pop, clear, query and rejected
//   pushes go through the top read, its wait and the done state (the top
//   read and wait are skipped when the stack is left empty); a push run onto
//   a non-empty stack first reads the current top's extremes. The push run
//   writes one entry per cycle through the single memory write port, and
//   one request is in progress at a time: the sequencer is ready again in the
//   cycle after the previous result moves to the output register.
//   A finished result waits in the output register while the next request
//   is taken; if i_ready stays low, that next result is held in the
//   sequencer and no further request is taken until the register frees.
//   Reset empties the stack (fill level zero) and drops any pending result;
//   memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_block_push_pop (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_start_value,
    input  wire logic [10:0]        i_count,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [10:0]             o_depth_used,
    output logic signed [31:0]      o_top_value,
    output logic                    o_is_empty,
    output logic signed [31:0]      o_min_value,
    output logic signed [31:0]      o_max_value,
    output logic [1:0]              o_status
);

    import lsbp_pkg::*;

    t_result  eng_res;
    logic     eng_res_valid;
    logic     eng_res_ready;
    t_ram_cmd ram_cmd;
    t_entry   ram_rd_data;

    logic     r_out_valid;
    t_result  r_out;

    // sequencer
    lsbp_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .o_req_ready   (o_ready),
        .i_req_type    (t_req'(i_req_type)),
        .i_req_start   (i_start_value),
        .i_req_count   (i_count),
        .o_res_valid   (eng_res_valid),
        .i_res_ready   (eng_res_ready),
        .o_res         (eng_res),
        .o_ram_cmd     (ram_cmd),
        .i_ram_rd_data (ram_rd_data)
    );

    // entry memory with per-entry prefix extremes
    lsbp_ram #(
        .DATA_W ($bits(t_entry)),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_cmd.wr_en),
        .i_wr_addr (ram_cmd.wr_addr),
        .i_wr_data (ram_cmd.wr_data),
        .i_rd_en   (ram_cmd.rd_en),
        .i_rd_addr (ram_cmd.rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // output register
    assign eng_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_ready) begin
            r_out_valid <= eng_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_ready && eng_res_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_depth_used = r_out.depth;
    assign o_top_value  = r_out.top;
    assign o_is_empty   = r_out.empty;
    assign o_min_value  = r_out.min;
    assign o_max_value  = r_out.max;
    assign o_status     = r_out.status;

endmodule

`default_nettype wire

// ===== rtl/lsbp_checker.sv =====
// ----------------------------------------------------------------------------
// lsbp_checker
// Port-level checks of the stack results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [10:0]        o_depth_used,
    input wire logic signed [31:0] o_top_value,
    input wire logic               o_is_empty,
    input wire logic signed [31:0] o_min_value,
    input wire logic signed [31:0] o_max_value
);

    // empty flag agrees with the reported depth
    a_empty_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_depth_used == 11'd0)))
        else $error("empty flag and depth disagree");

    // an empty stack reports zero top, min and max
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |->
        (o_top_value == 32'sd0 && o_min_value == 32'sd0 && o_max_value == 32'sd0))
        else $error("empty result with nonzero values");

    // the top lies between the stored extremes
    a_top_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_empty) |->
        (o_min_value <= o_top_value && o_top_value <= o_max_value))
        else $error("top outside min/max");

    // one request in progress at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while another is in progress");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_top_value)))
        else $error("stalled result changed");

endmodule

bind lifo_stack_block_push_pop lsbp_checker u_lsbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_depth_used (o_depth_used),
    .o_top_value  (o_top_value),
    .o_is_empty   (o_is_empty),
    .o_min_value  (o_min_value),
    .o_max_value  (o_max_value)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block push/pop LIFO stack. A queue of requests
// (directed corner cases, then a weighted random mix) feeds a clocked driver;
// every accepted request updates a local stack copy that predicts the result.
// A clocked monitor compares each result transfer field by field.
// ----------------------------------------------------------------------------

module tb_top;

    import lsbp_pkg::*;

    localparam int CYCLE_LIMIT      = 2_500_000;
    localparam int N_RANDOM         = 557;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int BURST_LO         = 300;
    localparam int BURST_HI         = 360;
    localparam int SETTLE_CYCLES    = 50;

    // one request as queued for the driver
    typedef struct {
        t_req                      kind;
        logic signed [VALUE_W-1:0] start;
        logic [COUNT_W-1:0]        count;
        int unsigned               gap;
        bit                        drain;
    } stack_req_t;

    // one predicted result
    typedef struct {
        logic [COUNT_W-1:0]        depth;
        logic signed [VALUE_W-1:0] top;
        logic                      empty;
        logic signed [VALUE_W-1:0] min;
        logic signed [VALUE_W-1:0] max;
        t_status                   status;
    } stack_snapshot_t;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_req_type    = REQ_QUERY;
    logic signed [VALUE_W-1:0] i_start_value = '0;
    logic [COUNT_W-1:0]        i_count       = '0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic [COUNT_W-1:0]        o_depth_used;
    logic signed [VALUE_W-1:0] o_top_value;
    logic                      o_is_empty;
    logic signed [VALUE_W-1:0] o_min_value;
    logic signed [VALUE_W-1:0] o_max_value;
    logic [1:0]                o_status;

    lifo_stack_block_push_pop dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_start_value (i_start_value),
        .i_count       (i_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_depth_used  (o_depth_used),
        .o_top_value   (o_top_value),
        .o_is_empty    (o_is_empty),
        .o_min_value   (o_min_value),
        .o_max_value   (o_max_value),
        .o_status      (o_status)
    );

    // local copy of the stack
    logic signed [VALUE_W-1:0] stack_words [STACK_DEPTH];
    int unsigned               stack_fill = 0;

    stack_req_t      pending_q [$];
    stack_snapshot_t predicted_snapshots [$];
    stack_req_t      cur_req;

    int unsigned gap_count   = 0;
    int unsigned rx_hold     = 0;
    int unsigned n_built     = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_results   = 0;
    int unsigned n_fail      = 0;
    int unsigned cycle_count = 0;

    // coverage tallies for the summary
    int unsigned n_kind [4];
    int unsigned n_underflow = 0;
    int unsigned n_overflow  = 0;
    int unsigned peak_fill   = 0;

    // apply one request to the local stack and queue the result it gives
    function automatic void stack_apply(stack_req_t r);
        stack_snapshot_t           s;
        logic signed [VALUE_W-1:0] word;
        s.status = STAT_OK;
        case (r.kind)
            REQ_PUSH: begin
                if (int'(r.count) > STACK_DEPTH - int'(stack_fill)) begin
                    s.status = STAT_OVERFLOW;
                end else begin
                    word = r.start;
                    for (int i = 0; i < int'(r.count); i++) begin
                        stack_words[stack_fill] = word;
                        stack_fill++;
                        word = word + 1;
                    end
                end
            end
            REQ_POP: begin
                if (r.count > stack_fill) begin
                    stack_fill = 0;
                    s.status   = STAT_UNDERFLOW;
                end else begin
                    stack_fill -= r.count;
                end
            end
            REQ_CLEAR: stack_fill = 0;
            default: ;
        endcase

        // top and true extremes over every stored entry, zeros when empty
        s.top = '0;
        s.min = '0;
        s.max = '0;
        if (stack_fill > 0) begin
            s.top = stack_words[stack_fill - 1];
            s.min = stack_words[0];
            s.max = stack_words[0];
            for (int i = 1; i < int'(stack_fill); i++) begin
                if (stack_words[i] < s.min) s.min = stack_words[i];
                if (stack_words[i] > s.max) s.max = stack_words[i];
            end
        end
        s.depth = stack_fill[COUNT_W-1:0];
        s.empty = (stack_fill == 0);
        predicted_snapshots.push_back(s);

        n_kind[r.kind]++;
        if (s.status == STAT_UNDERFLOW) n_underflow++;
        if (s.status == STAT_OVERFLOW) n_overflow++;
        if (stack_fill > peak_fill) peak_fill = stack_fill;
    endfunction

    // append a request with its own lead-in gap
    task automatic queue_request(t_req kind, logic signed [VALUE_W-1:0] start, int count);
        stack_req_t r;
        r.kind  = kind;
        r.start = start;
        r.count = count[COUNT_W-1:0];
        if (n_built >= BURST_LO && n_built < BURST_HI)
            r.gap = 0;
        else
            r.gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
        // wait for the stack to go quiet before the first random request and once more
        r.drain = (n_built == 23 || n_built == 400);
        pending_q.push_back(r);
        n_built++;
    endtask

    // weighted random request: mostly small runs, a few full-size and oversize ones
    task automatic queue_random_request();
        int unsigned sel;
        int unsigned sz;
        int          cnt;
        logic [31:0] start;
        sel   = $urandom_range(99);
        sz    = $urandom_range(99);
        start = $urandom;
        if ($urandom_range(7) == 0) start = 32'h7FFF_FFFF - $urandom_range(20);
        if (sel < 40) begin
            if (sz < 3)      cnt = $urandom_range(2047, 1025);
            else if (sz < 8) cnt = $urandom_range(1024, 100);
            else             cnt = $urandom_range(32);
            queue_request(REQ_PUSH, start, cnt);
        end else if (sel < 75) begin
            if (sz < 3)      cnt = $urandom_range(2047, 1025);
            else if (sz < 8) cnt = $urandom_range(300);
            else             cnt = $urandom_range(24);
            queue_request(REQ_POP, start, cnt);
        end else if (sel < 80) begin
            queue_request(REQ_CLEAR, start, $urandom_range(2047));
        end else begin
            queue_request(REQ_QUERY, start, $urandom_range(2047));
        end
    endtask

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin : req_driver
        stack_req_t nxt;
        logic       offering;
        logic       launch;
        logic       took;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            gap_count <= 0;
        end else begin
            took     = i_valid && o_ready;
            offering = i_valid && !took;
            launch   = 1'b0;
            if (took) begin
                stack_apply(cur_req);
                n_accepted <= n_accepted + 1;
            end
            if (!offering && pending_q.size() > 0) begin
                nxt = pending_q[0];
                if (nxt.drain && (n_accepted + took) != n_results) begin
                    // hold until every outstanding result has come back
                end else if (gap_count < nxt.gap) begin
                    gap_count <= gap_count + 1;
                end else begin
                    void'(pending_q.pop_front());
                    cur_req       <= nxt;
                    i_req_type    <= nxt.kind;
                    i_start_value <= nxt.start;
                    i_count       <= nxt.count;
                    gap_count     <= 0;
                    launch = 1'b1;
                end
            end
            i_valid <= offering || launch;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : result_monitor
        stack_snapshot_t s;
        int unsigned     h;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold <= 0;
        end else begin
            h = rx_hold;
            if (o_valid && i_ready) begin
                n_results <= n_results + 1;
                if (predicted_snapshots.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    n_fail++;
                end else begin
                    s = predicted_snapshots.pop_front();
                    if (o_depth_used !== s.depth) begin
                        $error("depth_used: expected %0d, got %0d", s.depth, o_depth_used);
                        n_fail++;
                    end
                    if (o_top_value !== s.top) begin
                        $error("top_value: expected %0d, got %0d", s.top, o_top_value);
                        n_fail++;
                    end
                    if (o_is_empty !== s.empty) begin
                        $error("is_empty: expected %0d, got %0d", s.empty, o_is_empty);
                        n_fail++;
                    end
                    if (o_min_value !== s.min) begin
                        $error("min_value: expected %0d, got %0d", s.min, o_min_value);
                        n_fail++;
                    end
                    if (o_max_value !== s.max) begin
                        $error("max_value: expected %0d, got %0d", s.max, o_max_value);
                        n_fail++;
                    end
                    if (o_status !== s.status) begin
                        $error("status: expected %0d, got %0d", s.status, o_status);
                        n_fail++;
                    end
                end
                // stall before the next result; one long hold lets requests pile up
                if (n_results + 1 == LONG_HOLD_AT)
                    h = LONG_HOLD_CYCLES;
                else if (n_results + 1 >= BURST_LO && n_results + 1 < BURST_HI)
                    h = 0;
                else
                    h = ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
            end else if (h > 0) begin
                h = h - 1;
            end
            i_ready <= (h == 0);
            rx_hold <= h;
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus and end of run
    initial begin
        // empty-stack corner cases
        queue_request(REQ_QUERY, $urandom, 2047);
        queue_request(REQ_POP, $urandom, 0);
        queue_request(REQ_POP, $urandom, 5);
        queue_request(REQ_PUSH, $urandom, 0);
        // run that wraps past the largest positive value
        queue_request(REQ_PUSH, 32'sh7FFF_FFFE, 3);
        queue_request(REQ_QUERY, $urandom, $urandom_range(2047));
        queue_request(REQ_PUSH, -32'sd1, 2);
        queue_request(REQ_POP, $urandom, 1);
        queue_request(REQ_POP, $urandom, 0);
        queue_request(REQ_PUSH, $urandom, 2047);
        queue_request(REQ_CLEAR, $urandom, $urandom_range(2047));
        queue_request(REQ_CLEAR, $urandom, $urandom_range(2047));
        // fill to the brim from the most negative value
        queue_request(REQ_PUSH, 32'sh8000_0000, 1024);
        queue_request(REQ_PUSH, $urandom, 1);
        queue_request(REQ_PUSH, $urandom, 0);
        queue_request(REQ_QUERY, $urandom, $urandom_range(2047));
        queue_request(REQ_POP, $urandom, 1000);
        queue_request(REQ_POP, $urandom, 100);
        // full again, ending on the largest positive value, then popped exactly empty
        queue_request(REQ_PUSH, 32'sh7FFF_FC00, 1024);
        queue_request(REQ_POP, $urandom, 1024);
        queue_request(REQ_PUSH, 32'sh5555_5555, 5);
        queue_request(REQ_PUSH, 32'shAAAA_AAAA, 4);
        queue_request(REQ_POP, $urandom, 2047);
        for (int k = 0; k < N_RANDOM; k++) queue_random_request();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all requests out, then all results back, then a short settle
        while (pending_q.size() != 0 || i_valid) @(posedge i_clk);
        while (n_results != n_accepted) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (predicted_snapshots.size() != 0) begin
            $error("%0d results never arrived", predicted_snapshots.size());
            n_fail++;
        end
        $display("covered %0d requests: %0d push, %0d pop, %0d clear, %0d query",
                 n_accepted, n_kind[REQ_PUSH], n_kind[REQ_POP], n_kind[REQ_CLEAR],
                 n_kind[REQ_QUERY]);
        $display("underflows %0d, rejected pushes %0d, deepest fill %0d of %0d",
                 n_underflow, n_overflow, peak_fill, STACK_DEPTH);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== lifo_stack_block_push_pop.f =====
rtl/lsbp_pkg.sv
rtl/lsbp_ram.sv
rtl/lsbp_engine.sv
rtl/lifo_stack_block_push_pop.sv
rtl/lsbp_checker.sv
tb/tb_top.sv
